### sv/lqws_pkg.sv
`default_nettype none

package lqws_pkg;

  localparam int WINDOW     = 10;
  localparam int LOSS_SCALE = 10000;

  localparam int MET_W  = 8;
  localparam int LOSS_W = 14;
  localparam int FILL_W = 7;

  // pointer, tally and running sum widths follow from the window depth
  localparam int WP_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = $clog2(WINDOW * 128) + 1;
  localparam int LNUM_W = $clog2(WINDOW * LOSS_SCALE + 1);
  localparam int DIV_W  = (LNUM_W > SUM_W) ? LNUM_W : SUM_W;
  localparam int STEP_W = $clog2(DIV_W + 1);

  typedef struct packed {
    logic                    received;
    logic signed [MET_W-1:0] rssi;
    logic signed [MET_W-1:0] snr;
  } in_t;

  typedef struct packed {
    logic                    last_received;
    logic signed [MET_W-1:0] last_rssi;
    logic signed [MET_W-1:0] last_snr;
    logic signed [MET_W-1:0] avg_rssi;
    logic signed [MET_W-1:0] avg_snr;
    logic [LOSS_W-1:0]       loss_hundredths_pct;
    logic [FILL_W-1:0]       filled_count;
  } out_t;

  typedef struct packed {
    logic                    rx;
    logic signed [MET_W-1:0] rs;
    logic signed [MET_W-1:0] sn;
  } ent_t;

  typedef enum logic [1:0] {
    DSEL_RSSI,
    DSEL_SNR,
    DSEL_LOSS
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_RSSI_GO,
    ST_RSSI_WAIT,
    ST_SNR_GO,
    ST_SNR_WAIT,
    ST_LOSS_GO,
    ST_LOSS_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic     load_in;
    logic     update;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_rssi;
    logic     cap_snr;
    logic     cap_loss;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

### sv/lqws_div.sv
`default_nettype none

module lqws_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [lqws_pkg::DIV_W-1:0]   dividend,
  input  wire logic [lqws_pkg::CNT_W-1:0]   divisor,
  output logic                              busy,
  output logic                              done,
  output logic [lqws_pkg::DIV_W-1:0]        quotient
);

  logic [lqws_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic [lqws_pkg::DIV_W-1:0]  q_r, q_nxt;
  logic [lqws_pkg::CNT_W-1:0]  rem_r, rem_nxt;
  logic [lqws_pkg::CNT_W-1:0]  dsr_r, dsr_nxt;
  logic                        done_r, done_nxt;
  logic [lqws_pkg::CNT_W:0]    rem_sh;

  assign busy     = (cnt_r != '0);
  assign done     = done_r;
  assign quotient = q_r;

  // restoring division, one quotient bit per cycle, msb first
  always_comb begin
    rem_sh   = {rem_r, q_r[lqws_pkg::DIV_W-1]};
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = lqws_pkg::STEP_W'(lqws_pkg::DIV_W);
      q_nxt   = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
    end else if (busy) begin
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == lqws_pkg::STEP_W'(1));
      if (rem_sh >= {1'b0, dsr_r}) begin
        rem_nxt = lqws_pkg::CNT_W'(rem_sh - {1'b0, dsr_r});
        q_nxt   = {q_r[lqws_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[lqws_pkg::CNT_W-1:0];
        q_nxt   = {q_r[lqws_pkg::DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

endmodule

`default_nettype wire

### sv/lqws_datapath.sv
`default_nettype none

module lqws_datapath (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire lqws_pkg::in_t  in_data,
  input  wire lqws_pkg::cmd_t cmd,
  input  wire logic           out_stall,
  output lqws_pkg::sts_t      sts,
  output logic                out_valid,
  output lqws_pkg::out_t      out_data
);

  lqws_pkg::in_t  in_r;
  lqws_pkg::ent_t rd_r;
  lqws_pkg::ent_t ring [lqws_pkg::WINDOW];
  lqws_pkg::ent_t new_ent;
  lqws_pkg::out_t out_r, out_nxt;

  logic [lqws_pkg::WP_W-1:0]         wp_r, wp_nxt;
  logic                              wrapped_r, wrapped_nxt;
  logic signed [lqws_pkg::SUM_W-1:0] rsum_r, rsum_nxt;
  logic signed [lqws_pkg::SUM_W-1:0] ssum_r, ssum_nxt;
  logic [lqws_pkg::CNT_W-1:0]        tally_r, tally_nxt;
  logic                              out_valid_r, out_valid_nxt;

  logic signed [lqws_pkg::MET_W-1:0] avg_rssi_r, avg_snr_r;
  logic [lqws_pkg::LOSS_W-1:0]       loss_r;

  logic                              evict;
  logic [lqws_pkg::CNT_W-1:0]        filled;
  logic [lqws_pkg::SUM_W-1:0]        rabs, sabs;
  logic [lqws_pkg::DIV_W-1:0]        dividend, quotient;
  logic [lqws_pkg::CNT_W-1:0]        divisor;
  logic                              div_busy, div_done;
  logic [8:0]                        q9, r_val, s_val;

  // timeouts are stored and reported with zero metrics
  assign new_ent.rx = in_r.received;
  assign new_ent.rs = in_r.received ? in_r.rssi : '0;
  assign new_ent.sn = in_r.received ? in_r.snr : '0;

  assign evict  = wrapped_r && rd_r.rx;
  assign filled = wrapped_r ? lqws_pkg::CNT_W'(lqws_pkg::WINDOW) : lqws_pkg::CNT_W'(wp_r);

  always_comb begin
    wp_nxt      = wp_r;
    wrapped_nxt = wrapped_r;
    rsum_nxt    = rsum_r;
    ssum_nxt    = ssum_r;
    tally_nxt   = tally_r;
    if (cmd.update) begin
      rsum_nxt  = rsum_r - (evict ? lqws_pkg::SUM_W'(rd_r.rs) : '0)
                         + lqws_pkg::SUM_W'(new_ent.rs);
      ssum_nxt  = ssum_r - (evict ? lqws_pkg::SUM_W'(rd_r.sn) : '0)
                         + lqws_pkg::SUM_W'(new_ent.sn);
      tally_nxt = tally_r - lqws_pkg::CNT_W'(evict) + lqws_pkg::CNT_W'(new_ent.rx);
      if (wp_r == lqws_pkg::WP_W'(lqws_pkg::WINDOW - 1)) begin
        wp_nxt      = '0;
        wrapped_nxt = 1'b1;
      end else begin
        wp_nxt = wp_r + 1'b1;
      end
    end
  end

  assign rabs = rsum_r[lqws_pkg::SUM_W-1] ? lqws_pkg::SUM_W'(-rsum_r) : rsum_r;
  assign sabs = ssum_r[lqws_pkg::SUM_W-1] ? lqws_pkg::SUM_W'(-ssum_r) : ssum_r;

  always_comb begin
    unique case (cmd.div_sel)
      lqws_pkg::DSEL_RSSI: begin
        dividend = lqws_pkg::DIV_W'(rabs);
        divisor  = tally_r;
      end
      lqws_pkg::DSEL_SNR: begin
        dividend = lqws_pkg::DIV_W'(sabs);
        divisor  = tally_r;
      end
      lqws_pkg::DSEL_LOSS: begin
        dividend = lqws_pkg::DIV_W'(lqws_pkg::DIV_W'(filled - tally_r) *
                                    lqws_pkg::DIV_W'(lqws_pkg::LOSS_SCALE));
        divisor  = filled;
      end
      default: begin
        dividend = '0;
        divisor  = filled;
      end
    endcase
  end

  lqws_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  // the mean magnitude never exceeds 128, so nine bits carry the sign fix
  assign q9    = quotient[8:0];
  assign r_val = rsum_r[lqws_pkg::SUM_W-1] ? 9'(-q9) : q9;
  assign s_val = ssum_r[lqws_pkg::SUM_W-1] ? 9'(-q9) : q9;

  always_comb begin
    out_nxt                     = out_r;
    out_nxt.last_received       = new_ent.rx;
    out_nxt.last_rssi           = new_ent.rs;
    out_nxt.last_snr            = new_ent.sn;
    out_nxt.avg_rssi            = avg_rssi_r;
    out_nxt.avg_snr             = avg_snr_r;
    out_nxt.loss_hundredths_pct = loss_r;
    out_nxt.filled_count        = lqws_pkg::FILL_W'(filled);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      rsum_r      <= '0;
      ssum_r      <= '0;
      tally_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      wrapped_r   <= wrapped_nxt;
      rsum_r      <= rsum_nxt;
      ssum_r      <= ssum_nxt;
      tally_r     <= tally_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ring read at the write pointer each cycle, so the evicted entry is ready at update
  always_ff @(posedge clk) begin
    rd_r <= ring[wp_r];
    if (cmd.update) begin
      ring[wp_r] <= new_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.cap_rssi) begin
      avg_rssi_r <= (tally_r == '0) ? '0 : r_val[7:0];
    end
    if (cmd.cap_snr) begin
      avg_snr_r <= (tally_r == '0) ? '0 : s_val[7:0];
    end
    if (cmd.cap_loss) begin
      loss_r <= quotient[lqws_pkg::LOSS_W-1:0];
    end
    if (cmd.load_out) begin
      out_r <= out_nxt;
    end
  end

  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

`ifndef NO_ASSERTIONS
  a_tally_max: assert property (@(posedge clk) disable iff (!rst_n)
    tally_r <= lqws_pkg::CNT_W'(lqws_pkg::WINDOW))
    else $error("received tally exceeds window");

  a_tally_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !wrapped_r |-> (tally_r <= lqws_pkg::CNT_W'(wp_r)))
    else $error("received tally exceeds filled entries");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider started while busy");

  a_cap_done: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.cap_rssi || cmd.cap_snr || cmd.cap_loss) |-> div_done)
    else $error("quotient captured before divider finished");
`endif

endmodule

`default_nettype wire

### sv/lqws_ctrl.sv
`default_nettype none

module lqws_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire lqws_pkg::sts_t sts,
  output logic                in_stall,
  output lqws_pkg::cmd_t      cmd
);

  lqws_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lqws_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_sel = lqws_pkg::DSEL_RSSI;
    in_stall  = 1'b1;
    unique case (state_r)
      lqws_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_nxt = lqws_pkg::ST_UPDATE;
        end
      end
      lqws_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = lqws_pkg::ST_RSSI_GO;
      end
      lqws_pkg::ST_RSSI_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = lqws_pkg::DSEL_RSSI;
        state_nxt     = lqws_pkg::ST_RSSI_WAIT;
      end
      lqws_pkg::ST_RSSI_WAIT: begin
        cmd.cap_rssi = sts.div_done;
        if (sts.div_done) begin
          state_nxt = lqws_pkg::ST_SNR_GO;
        end
      end
      lqws_pkg::ST_SNR_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = lqws_pkg::DSEL_SNR;
        state_nxt     = lqws_pkg::ST_SNR_WAIT;
      end
      lqws_pkg::ST_SNR_WAIT: begin
        cmd.cap_snr = sts.div_done;
        if (sts.div_done) begin
          state_nxt = lqws_pkg::ST_LOSS_GO;
        end
      end
      lqws_pkg::ST_LOSS_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = lqws_pkg::DSEL_LOSS;
        state_nxt     = lqws_pkg::ST_LOSS_WAIT;
      end
      lqws_pkg::ST_LOSS_WAIT: begin
        cmd.cap_loss = sts.div_done;
        if (sts.div_done) begin
          state_nxt = lqws_pkg::ST_OUT;
        end
      end
      lqws_pkg::ST_OUT: begin
        // hold the finished beat until the output register frees up
        cmd.load_out = sts.out_free;
        if (sts.out_free) begin
          state_nxt = lqws_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lqws_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/link_quality_window_stats.sv
// channel | ports                          | direction | payload
// input   | in_valid, in_stall, in_data    | in        | lqws_pkg::in_t
// result  | out_valid, out_stall, out_data | out       | lqws_pkg::out_t
//
// one beat in, one beat out; the serial divider runs once for each of the two
// averages and the loss figure, and in_stall stays high from an accepted beat
// until its result is loaded into the output register
// the next beat is taken while the previous result waits in the output register
// synchronous active-low reset clears pointer, sums, tally and valid flags;
// ring contents stay unknown until written
`default_nettype none

module link_quality_window_stats (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire lqws_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output lqws_pkg::out_t      out_data
);

  lqws_pkg::cmd_t cmd;
  lqws_pkg::sts_t sts;

  lqws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  lqws_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
